>>> rtl/assert_macros.svh
// Assertion macros for the semaphore unit's RTL.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CSBW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csbw: same-cycle check failed");
// Next-cycle implication.
`define CSBW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csbw: next-cycle check failed");
`else
`define CSBW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSBW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/csbw_pkg.sv
// Package for the counting semaphore unit: sizes, codes and shared types.
// No dependencies.
`default_nettype none
package csbw_pkg;

    localparam int MAX_THREADS    = 16;
    localparam int NUM_SEMAPHORES = 8;

    localparam int ACTION_W = 2;
    localparam int SEM_W    = 3;
    localparam int COUNT_W  = 16;
    localparam int THREAD_W = 4;
    localparam int RING_W   = 5;

    localparam logic [RING_W-1:0] RING_RESET = RING_W'(MAX_THREADS);

    typedef enum logic [ACTION_W-1:0] {
        ACT_INIT   = 2'd0,
        ACT_WAIT   = 2'd1,
        ACT_SIGNAL = 2'd2
    } csbw_action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_COMMIT
    } csbw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the request word
        logic calc;     // compute new count and waiter match vector
        logic commit;   // search, update state, load result register
    } csbw_cmd_t;

endpackage
`default_nettype wire

>>> rtl/csbw_if.sv
// Request and response channel interfaces for the semaphore unit.
// Depends on csbw_pkg.
`default_nettype none
interface csbw_req_if import csbw_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [SEM_W-1:0]           sem_index;
    logic signed [COUNT_W-1:0]  init_value;
    logic [THREAD_W-1:0]        caller_thread;

    modport source (output valid, action, sem_index, init_value, caller_thread,
                    input ready);
    modport sink   (input valid, action, sem_index, init_value, caller_thread,
                    output ready);
endinterface

interface csbw_rsp_if import csbw_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       must_yield;
    logic                       woke_valid;
    logic [THREAD_W-1:0]        woke_thread;
    logic signed [COUNT_W-1:0]  count_after;
    logic                       no_waiter;

    modport source (output valid, must_yield, woke_valid, woke_thread, count_after,
                    no_waiter, input ready);
    modport sink   (input valid, must_yield, woke_valid, woke_thread, count_after,
                    no_waiter, output ready);
endinterface
`default_nettype wire

>>> rtl/csbw_ctrl.sv
// Controller state machine for the semaphore unit; owns the result valid flag.
// Depends on csbw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module csbw_ctrl
    import csbw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output csbw_cmd_t      cmd
);

    csbw_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_free   = !out_valid_reg || out_ready;
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold until the result register can take the word
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    in_ready   = 1'b1;
                    cmd.load   = in_valid;
                    state_next = in_valid ? ST_CALC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    `CSBW_ASSERT_NXT(a_calc_then_commit, clk, rst_n, state_reg == ST_CALC, state_reg == ST_COMMIT)
    `CSBW_ASSERT_NXT(a_commit_sets_valid, clk, rst_n, cmd.commit, out_valid_reg)
    `CSBW_ASSERT_NXT(a_load_starts_calc, clk, rst_n, cmd.load, state_reg == ST_CALC)
    `CSBW_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.commit, !out_valid_reg || out_ready)

endmodule
`default_nettype wire

>>> rtl/csbw_dp.sv
// Datapath for the semaphore unit: counts, blocked marks, ring search, result.
// Depends on csbw_pkg.
`default_nettype none
module csbw_dp
    import csbw_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire csbw_cmd_t                  cmd,
    input  wire logic [ACTION_W-1:0]        action,
    input  wire logic [SEM_W-1:0]           sem_index,
    input  wire logic signed [COUNT_W-1:0]  init_value,
    input  wire logic [THREAD_W-1:0]        caller_thread,
    input  wire logic                       cfg_we,
    input  wire logic [RING_W-1:0]          cfg_wdata,
    output logic                            must_yield,
    output logic                            woke_valid,
    output logic [THREAD_W-1:0]             woke_thread,
    output logic signed [COUNT_W-1:0]       count_after,
    output logic                            no_waiter
);

    // request word
    logic [ACTION_W-1:0]        action_reg;
    logic [SEM_W-1:0]           sem_reg;
    logic signed [COUNT_W-1:0]  init_reg;
    logic [THREAD_W-1:0]        caller_reg;

    // architectural state
    logic [RING_W-1:0]          ring_reg;
    logic signed [COUNT_W-1:0]  count_reg [NUM_SEMAPHORES];
    logic [MAX_THREADS-1:0]     waiting_reg;
    logic [SEM_W-1:0]           wait_sem_reg [MAX_THREADS];

    // calc stage results
    logic signed [COUNT_W-1:0]  cnt_new_reg, cnt_new_next;
    logic                       in_range_reg, in_range_next;
    logic                       yield_reg, yield_next;
    logic                       search_reg, search_next;
    logic                       caller_in_reg, caller_in_next;
    logic [MAX_THREADS-1:0]     match_reg, match_next;
    logic [RING_W-1:0]          start_reg, start_next;

    // result register
    logic                       must_yield_reg, woke_valid_reg, no_waiter_reg;
    logic [THREAD_W-1:0]        woke_thread_reg;
    logic signed [COUNT_W-1:0]  count_after_reg;

    logic [RING_W-1:0]          ring_n;
    logic signed [COUNT_W-1:0]  cnt_cur;
    logic [MAX_THREADS-1:0]     upper, pick, onehot;
    logic [THREAD_W-1:0]        found_idx;
    logic                       found;

    // clamp ring size into 1..MAX_THREADS
    always_comb
    begin
        if (ring_reg == '0)
            ring_n = RING_W'(1);
        else if (ring_reg > RING_RESET)
            ring_n = RING_RESET;
        else
            ring_n = ring_reg;
    end

    // calc: new count and match vector
    always_comb
    begin
        in_range_next  = int'(sem_reg) < NUM_SEMAPHORES;
        cnt_cur        = count_reg[sem_reg];
        cnt_new_next   = cnt_cur;
        caller_in_next = RING_W'(caller_reg) < ring_n;
        unique case (action_reg)
            ACT_INIT:
                cnt_new_next = init_reg;
            ACT_WAIT:
                if (cnt_cur != {1'b1, {(COUNT_W-1){1'b0}}})
                    cnt_new_next = cnt_cur - COUNT_W'(1);
            ACT_SIGNAL:
                if (cnt_cur != {1'b0, {(COUNT_W-1){1'b1}}})
                    cnt_new_next = cnt_cur + COUNT_W'(1);
            default:
                cnt_new_next = cnt_cur;
        endcase
        yield_next  = (action_reg == ACT_WAIT) && cnt_new_next[COUNT_W-1];
        search_next = (action_reg == ACT_SIGNAL)
                      && (cnt_new_next[COUNT_W-1] || cnt_new_next == '0);
        start_next  = caller_in_next ? RING_W'(caller_reg) + RING_W'(1) : '0;
        for (int i = 0; i < MAX_THREADS; i++)
            match_next[i] = waiting_reg[i] && (wait_sem_reg[i] == sem_reg)
                            && (RING_W'(i) < ring_n);
    end

    // commit: rotating priority pick, lowest index at or after the start first
    always_comb
    begin
        for (int i = 0; i < MAX_THREADS; i++)
            upper[i] = match_reg[i] && (RING_W'(i) >= start_reg);
        pick   = (|upper) ? upper : match_reg;
        onehot = pick & (~pick + MAX_THREADS'(1));
        found  = |match_reg;
        found_idx = '0;
        for (int i = 0; i < MAX_THREADS; i++)
            if (onehot[i])
                found_idx = found_idx | THREAD_W'(i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg    <= RING_RESET;
            waiting_reg <= '0;
            for (int s = 0; s < NUM_SEMAPHORES; s++)
                count_reg[s] <= '0;
            for (int t = 0; t < MAX_THREADS; t++)
                wait_sem_reg[t] <= '0;
        end
        else
        begin
            if (cfg_we)
                ring_reg <= cfg_wdata;
            if (cmd.commit && in_range_reg)
            begin
                count_reg[sem_reg] <= cnt_new_reg;
                if (yield_reg && caller_in_reg)
                begin
                    waiting_reg[caller_reg]  <= 1'b1;
                    wait_sem_reg[caller_reg] <= sem_reg;
                end
                if (search_reg && found)
                    waiting_reg[found_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            sem_reg    <= sem_index;
            init_reg   <= init_value;
            caller_reg <= caller_thread;
        end
        if (cmd.calc)
        begin
            cnt_new_reg   <= cnt_new_next;
            in_range_reg  <= in_range_next;
            yield_reg     <= yield_next;
            search_reg    <= search_next;
            caller_in_reg <= caller_in_next;
            match_reg     <= match_next;
            start_reg     <= start_next;
        end
        if (cmd.commit)
        begin
            must_yield_reg  <= in_range_reg && yield_reg;
            woke_valid_reg  <= in_range_reg && search_reg && found;
            woke_thread_reg <= (in_range_reg && search_reg && found) ? found_idx : '0;
            count_after_reg <= in_range_reg ? cnt_new_reg : '0;
            no_waiter_reg   <= in_range_reg && search_reg && !found;
        end
    end

    assign must_yield  = must_yield_reg;
    assign woke_valid  = woke_valid_reg;
    assign woke_thread = woke_thread_reg;
    assign count_after = count_after_reg;
    assign no_waiter   = no_waiter_reg;

endmodule
`default_nettype wire

>>> rtl/counting_semaphore_block_wake_core.sv
// Counting semaphore unit with blocking wait and round-robin wake.
// A request is captured, then calc, then commit loads the result and sets response valid.
// Commit stalls while the last response waits; a queued request is captured at commit.
// Reset (rst_n low, async): counts 0, no thread blocked, ring size 16, no result.
// Depends on csbw_pkg, csbw_if, csbw_ctrl and csbw_dp.
`default_nettype none
module counting_semaphore_block_wake_core
    import csbw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    csbw_req_if.sink                req,
    csbw_rsp_if.source              rsp,
    input  wire logic               cfg_we,
    input  wire logic [RING_W-1:0]  cfg_wdata
);

    csbw_cmd_t cmd;

    // Controller: sequence capture -> calc -> commit. The next request word
    // is taken in the commit cycle. A response waiting on rsp.ready stalls
    // the commit, and with it the capture of a queued request word, until
    // the result register frees up.
    csbw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Datapath: count update and waiter match in calc, then the rotating
    // search over blocked marks (starting after the caller, caller last),
    // state write-back and result load in commit. Ring size register is
    // written here directly; the user must write it only while idle (not enforced).
    csbw_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (req.action),
        .sem_index     (req.sem_index),
        .init_value    (req.init_value),
        .caller_thread (req.caller_thread),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .must_yield    (rsp.must_yield),
        .woke_valid    (rsp.woke_valid),
        .woke_thread   (rsp.woke_thread),
        .count_after   (rsp.count_after),
        .no_waiter     (rsp.no_waiter)
    );

endmodule
`default_nettype wire
